// ===== src/berlekamp_massey_locator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Berlekamp-Massey locator unit
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BERLEKAMP_MASSEY_LOCATOR_UNIT_ASSERT_SVH
`define BERLEKAMP_MASSEY_LOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BML_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bml: same-cycle check failed");

// next-cycle implication
`define BML_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bml: next-cycle check failed");

`endif

// ===== src/bml_pkg.sv =====
// ----------------------------------------------------------------------------
// bml_pkg
// Types and fixed port widths of the Berlekamp-Massey locator unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bml_pkg;

   localparam int unsigned ELEM_PORT_W = 13;  // field element width on ports
   localparam int unsigned IDX_PORT_W  = 6;   // coefficient index width on ports
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 24;
   localparam logic [ELEM_PORT_W-1:0] POLY_RESET = 13'd27;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DISC_PRE,
      ST_DISC,
      ST_INV_SQ,
      ST_INV_MUL,
      ST_SCALE,
      ST_UPDATE,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== src/bml_ram.sv =====
// ----------------------------------------------------------------------------
// bml_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bml_ram #(
   parameter int unsigned WIDTH = 13,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/bml_gfmul.sv =====
// ----------------------------------------------------------------------------
// bml_gfmul
// GF(2^m) multiplier, shift-and-reduce by a programmable polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module bml_gfmul #(
   parameter int unsigned FIELD_BITS = 13
) (
   input  wire logic [FIELD_BITS-1:0] poly,
   input  wire logic [FIELD_BITS-1:0] op_a,
   input  wire logic [FIELD_BITS-1:0] op_b,
   output logic      [FIELD_BITS-1:0] product
);

   always_comb begin : mul_loop
      logic [FIELD_BITS:0] acc;
      logic [FIELD_BITS:0] red;
      acc = '0;
      red = {1'b1, poly};
      for (int bit_n = FIELD_BITS - 1; bit_n >= 0; bit_n--) begin
         acc = {acc[FIELD_BITS-1:0], 1'b0};
         if (acc[FIELD_BITS]) begin
            acc = acc ^ red;
         end
         if (op_b[bit_n]) begin
            acc = acc ^ {1'b0, op_a};
         end
      end
      product = acc[FIELD_BITS-1:0];
   end

endmodule

`default_nettype wire

// ===== src/berlekamp_massey_locator_unit.sv =====
// ----------------------------------------------------------------------------
// berlekamp_massey_locator_unit
// Collects 2T syndromes, runs 2T Berlekamp-Massey iterations on one shared
// GF multiplier and streams out the T+1 error locator coefficients.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)
//  req_    | in  | tdata: syndrome[12:0]; tlast: syndrome_last
//  rsp_    | out | tdata: coefficient[12:0], coeff_index[18:13]; tlast: coeff_last
//  csr_    | in  | data: field_poly[12:0], always ready
//
//  Loading: one syndrome word per cycle while idle.
//  Decoding: 2T iterations, each run in turn on the single shared multiplier
//  (discrepancy, m-1 square/multiply steps for the inverse, scale, update).
//  Output: T+1 words, one per cycle when rsp_tready is high; req_tready low
//  from the last syndrome until the final coefficient is taken.
//  Reset: synchronous, active high; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module berlekamp_massey_locator_unit #(
   parameter int unsigned FIELD_BITS = 13,
   parameter int unsigned MAX_ERRORS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [bml_pkg::REQ_DATA_W-1:0]     req_tdata,  // syndrome
   input  wire logic                               req_tlast,  // syndrome_last
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [bml_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // coefficient, coeff_index
   output logic                                    rsp_tlast,  // coeff_last
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bml_pkg::ELEM_PORT_W-1:0]    csr_data    // field_poly
);

   localparam int unsigned NCOEF = MAX_ERRORS + 1;
   localparam int unsigned NSYN  = 2 * MAX_ERRORS;
   localparam int unsigned AW    = $clog2(NSYN);
   localparam int unsigned IW    = $clog2(NCOEF);
   localparam int unsigned CW    = $clog2(NSYN + 1);
   localparam int unsigned EW    = CW + 2;
   localparam int unsigned JW    = $clog2(FIELD_BITS);
   localparam int unsigned FB    = FIELD_BITS;

   bml_pkg::state_type state_ff, state_in;

   logic [bml_pkg::ELEM_PORT_W-1:0] poly_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] k_ff, k_in;
   logic [IW-1:0] i_ff, i_in;
   logic [JW-1:0] j_ff, j_in;
   logic [CW:0]   len_ff, len_in;
   logic [FB-1:0] prevd_ff, prevd_in, d_ff, d_in, scale_ff, scale_in;
   logic [FB-1:0] invr_ff, invr_in, invsq_ff, invsq_in;
   logic [FB-1:0] hold_loc_ff, hold_loc_in, hold_corr_ff, hold_corr_in;
   logic          swap_ff, swap_in, sval_ff, sval_in;
   logic [FB-1:0] loc_ff [NCOEF];
   logic [FB-1:0] loc_in [NCOEF];
   logic [FB-1:0] corr_ff [NCOEF];
   logic [FB-1:0] corr_in [NCOEF];

   logic [FB-1:0] mul_a, mul_b, mul_p, syn_rd;
   logic          req_acc, rsp_acc, wr_en;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_idx, rd_diff;
   logic          rd_ok, last_i, last_j;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign wr_en   = req_acc && (cnt_ff < CW'(NSYN));
   assign last_i  = (i_ff == IW'(NCOEF - 1));
   assign last_j  = (j_ff == JW'(FB - 1));
   assign csr_ready = 1'b1;

   bml_ram #(.WIDTH(FB), .DEPTH(NSYN)) u_syn_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (FB'(req_tdata[bml_pkg::ELEM_PORT_W-1:0])),
      .rd_addr (rd_addr),
      .rd_data (syn_rd)
   );

   bml_gfmul #(.FIELD_BITS(FB)) u_mul (
      .poly    (FB'(poly_ff)),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   // syndrome index k-i; taps beyond k or beyond the loaded count read as zero
   always_comb begin
      rd_idx  = (state_ff == bml_pkg::ST_DISC) ? EW'(i_ff) + EW'(1) : EW'(i_ff);
      rd_diff = EW'(k_ff) - rd_idx;
      rd_ok   = (rd_idx <= EW'(k_ff)) && (rd_diff < EW'(cnt_ff));
      rd_addr = rd_diff[AW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bml_pkg::ST_LOAD:     if (req_acc && req_tlast) state_in = bml_pkg::ST_DISC_PRE;
         bml_pkg::ST_DISC_PRE: state_in = bml_pkg::ST_DISC;
         bml_pkg::ST_DISC:     if (last_i) state_in = bml_pkg::ST_INV_SQ;
         bml_pkg::ST_INV_SQ:   state_in = bml_pkg::ST_INV_MUL;
         bml_pkg::ST_INV_MUL:  state_in = last_j ? bml_pkg::ST_SCALE : bml_pkg::ST_INV_SQ;
         bml_pkg::ST_SCALE:    state_in = bml_pkg::ST_UPDATE;
         bml_pkg::ST_UPDATE: begin
            if (last_i) begin
               state_in = (k_ff == AW'(NSYN - 1)) ? bml_pkg::ST_OUT : bml_pkg::ST_DISC_PRE;
            end
         end
         bml_pkg::ST_OUT:      if (rsp_acc && last_i) state_in = bml_pkg::ST_LOAD;
         default:              state_in = bml_pkg::ST_LOAD;
      endcase
   end

   // outputs and multiplier operand select
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         bml_pkg::ST_LOAD:    req_tready = 1'b1;
         bml_pkg::ST_DISC: begin
            mul_a = loc_ff[0];
            mul_b = sval_ff ? syn_rd : '0;
         end
         bml_pkg::ST_INV_SQ: begin
            mul_a = invsq_ff;
            mul_b = invsq_ff;
         end
         bml_pkg::ST_INV_MUL: begin
            mul_a = invr_ff;
            mul_b = invsq_ff;
         end
         bml_pkg::ST_SCALE: begin
            mul_a = d_ff;
            mul_b = invr_ff;
         end
         bml_pkg::ST_UPDATE: begin
            mul_a = scale_ff;
            mul_b = corr_ff[0];
         end
         bml_pkg::ST_OUT:     rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_tdata = {{(bml_pkg::RSP_DATA_W - bml_pkg::ELEM_PORT_W
                         - bml_pkg::IDX_PORT_W){1'b0}},
                       bml_pkg::IDX_PORT_W'(i_ff), bml_pkg::ELEM_PORT_W'(loc_ff[0])};
   assign rsp_tlast = last_i;

   // datapath
   always_comb begin
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      len_in       = len_ff;
      prevd_in     = prevd_ff;
      d_in         = d_ff;
      scale_in     = scale_ff;
      invr_in      = invr_ff;
      invsq_in     = invsq_ff;
      hold_loc_in  = hold_loc_ff;
      hold_corr_in = hold_corr_ff;
      swap_in      = swap_ff;
      sval_in      = rd_ok;
      loc_in       = loc_ff;
      corr_in      = corr_ff;
      unique case (state_ff)
         bml_pkg::ST_LOAD: begin
            if (wr_en) cnt_in = cnt_ff + CW'(1);
            if (req_acc && req_tlast) begin
               for (int n = 0; n < NCOEF; n++) begin
                  loc_in[n]  = (n == 0) ? FB'(1) : '0;
                  corr_in[n] = (n == 1) ? FB'(1) : '0;
               end
               len_in   = '0;
               prevd_in = FB'(1);
               k_in     = '0;
               i_in     = '0;
            end
         end
         bml_pkg::ST_DISC_PRE: d_in = '0;
         bml_pkg::ST_DISC: begin
            d_in = d_ff ^ mul_p;
            for (int n = 0; n < NCOEF - 1; n++) loc_in[n] = loc_ff[n+1];
            loc_in[NCOEF-1] = loc_ff[0];
            i_in     = last_i ? '0 : i_ff + IW'(1);
            j_in     = JW'(1);
            invr_in  = FB'(1);
            invsq_in = prevd_ff;
         end
         bml_pkg::ST_INV_SQ:  invsq_in = mul_p;
         bml_pkg::ST_INV_MUL: begin
            invr_in = mul_p;
            j_in    = j_ff + JW'(1);
         end
         bml_pkg::ST_SCALE: begin
            scale_in     = mul_p;
            hold_loc_in  = '0;
            hold_corr_in = '0;
            swap_in      = (d_ff != '0) && ((CW+1)'(k_ff) >= {len_ff[CW-1:0], 1'b0});
            if ((d_ff != '0) && ((CW+1)'(k_ff) >= {len_ff[CW-1:0], 1'b0})) begin
               len_in   = (CW+1)'(k_ff) + (CW+1)'(1) - len_ff;
               prevd_in = d_ff;
            end
         end
         bml_pkg::ST_UPDATE: begin
            // corrections move up one place: x*corr or x*old locator
            for (int n = 0; n < NCOEF - 1; n++) begin
               loc_in[n]  = loc_ff[n+1];
               corr_in[n] = corr_ff[n+1];
            end
            loc_in[NCOEF-1]  = loc_ff[0] ^ mul_p;
            corr_in[NCOEF-1] = swap_ff ? hold_loc_ff : hold_corr_ff;
            hold_loc_in      = loc_ff[0];
            hold_corr_in     = corr_ff[0];
            i_in             = last_i ? '0 : i_ff + IW'(1);
            if (last_i) k_in = k_ff + AW'(1);
         end
         bml_pkg::ST_OUT: begin
            if (rsp_acc) begin
               for (int n = 0; n < NCOEF - 1; n++) loc_in[n] = loc_ff[n+1];
               loc_in[NCOEF-1] = loc_ff[0];
               i_in = last_i ? '0 : i_ff + IW'(1);
               if (last_i) cnt_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bml_pkg::ST_LOAD;
         poly_ff  <= bml_pkg::POLY_RESET;
         cnt_ff   <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         len_ff   <= '0;
         prevd_ff <= FB'(1);
         for (int n = 0; n < NCOEF; n++) begin
            loc_ff[n]  <= (n == 0) ? FB'(1) : '0;
            corr_ff[n] <= (n == 1) ? FB'(1) : '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) poly_ff <= csr_data;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         len_ff   <= len_in;
         prevd_ff <= prevd_in;
         loc_ff   <= loc_in;
         corr_ff  <= corr_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      d_ff         <= d_in;
      scale_ff     <= scale_in;
      invr_ff      <= invr_in;
      invsq_ff     <= invsq_in;
      hold_loc_ff  <= hold_loc_in;
      hold_corr_ff <= hold_corr_in;
      swap_ff      <= swap_in;
      sval_ff      <= sval_in;
   end

`include "berlekamp_massey_locator_unit_assert.svh"

   `BML_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(NSYN))
   `BML_ASSERT_IMP(a_prevd_nonzero, clock, reset, 1'b1, prevd_ff != '0)
   `BML_ASSERT_IMP(a_one_side, clock, reset, rsp_tvalid, !req_tready)
   `BML_ASSERT_NXT(a_last_starts, clock, reset, req_acc && req_tlast, state_ff == bml_pkg::ST_DISC_PRE)

endmodule

`default_nettype wire
